// ===== rtl/core/vpdb_pkg.sv =====
package vpdb_pkg;

  // Position data formats, as written to the data_format register.
  typedef enum logic [3:0] {
    FMT_S8       = 4'd0,
    FMT_U8       = 4'd1,
    FMT_S16      = 4'd2,
    FMT_U16      = 4'd3,
    FMT_S32      = 4'd4,
    FMT_U32      = 4'd5,
    FMT_HALF     = 4'd6,
    FMT_FLOAT    = 4'd7,
    FMT_DOUBLE   = 4'd8,
    FMT_S2101010 = 4'd9,
    FMT_U2101010 = 4'd10
  } fmt_e;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    CFG_DATA_FORMAT    = 4'd0,
    CFG_TWO_COMPONENTS = 4'd1,
    CFG_NORMALISE      = 4'd2,
    CFG_BOUNDS_ENABLE  = 4'd3
  } cfg_idx_e;

  // How a component is finished in the conversion pipeline.
  typedef enum logic [1:0] {
    KIND_SPEC = 2'd0,  // final bits already known
    KIND_INT  = 2'd1,  // integer magnitude, normalize and round
    KIND_RAT  = 2'd2,  // integer divided by 2^m-1, repeating fraction
    KIND_DBL  = 2'd3   // double precision, round to single
  } kind_e;

  // Width of the repeating block for a normalized narrow integer.
  typedef enum logic [1:0] {
    RW_8  = 2'd0,
    RW_16 = 2'd1,
    RW_9  = 2'd2,
    RW_10 = 2'd3
  } rw_e;

  localparam logic [31:0] F32_ONE         = 32'h3F80_0000;
  localparam logic [31:0] F32_QNAN        = 32'h7FC0_0000;
  localparam logic [31:0] F32_INF         = 32'h7F80_0000;
  localparam logic [31:0] F32_BOX_MIN     = 32'h5015_02F9;  // +1e10
  localparam logic [31:0] F32_BOX_MAX     = 32'hD015_02F9;  // -1e10
  localparam logic [31:0] F32_NEG_512_511 = 32'hBF80_4020;  // -512/511 rounded

  // Biased exponents for a leading one at bit 31 of an integer magnitude.
  localparam logic [7:0] E_INT        = 8'd158;
  localparam logic [7:0] E_INT_NORM32 = 8'd126;
  localparam logic [7:0] E_HALF_SUB   = 8'd134;
  localparam logic [7:0] E_RAT        = 8'd126;

  localparam logic [10:0] DBL_EXP_OVF  = 11'd1151;
  localparam logic [10:0] DBL_EXP_NORM = 11'd897;
  localparam logic [10:0] DBL_EXP_BIAS = 11'd896;
  localparam logic [10:0] DBL_EXP_SUB  = 11'd926;
  localparam logic [10:0] DBL_EXP_TINY = 11'd866;
  localparam logic [5:0]  DBL_SH_NORM  = 6'd29;
  localparam logic [5:0]  DBL_SH_MAX   = 6'd60;

  typedef struct packed {
    logic start;
    logic fold;
    logic ben;
  } ctrl_t;

  typedef struct packed {
    ctrl_t            ctrl;
    logic [3:0]       fmt;
    logic             norm;
    logic             two;
    logic [2:0][63:0] raw;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic        sign;
    logic [31:0] spec;
    logic [31:0] mag;
    logic [7:0]  ebase;
    rw_e         rw;
    logic [10:0] de;
    logic [51:0] dm;
  } s1_t;

  typedef struct packed {
    kind_e       kind;
    logic        sign;
    logic [31:0] spec;
    logic [31:0] mag;
    rw_e         rw;
    logic [4:0]  lz;
    logic [7:0]  exp;
    logic [5:0]  shift;
    logic [51:0] dm;
  } s2_t;

  typedef struct packed {
    logic        is_spec;
    logic        sign;
    logic [31:0] spec;
    logic [7:0]  exp;
    logic [23:0] sig;
    logic        guard;
    logic        sticky;
  } s3_t;

endpackage

// ===== rtl/core/vpdb_front.sv =====
module vpdb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                start_req_i,
  input  logic [63:0]         comp_x_raw_i,
  input  logic [63:0]         comp_y_raw_i,
  input  logic [63:0]         comp_z_raw_i,
  output logic                head_valid_o,
  output vpdb_pkg::item_t     head_o,
  input  logic                pop_i
);

  logic [3:0] fmt_q;
  logic       two_q;
  logic       norm_q;
  logic       ben_q;

  vpdb_pkg::item_t push_item;
  vpdb_pkg::item_t q_mem [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push;
  logic            pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= vpdb_pkg::FMT_FLOAT;
      two_q  <= 1'b0;
      norm_q <= 1'b0;
      ben_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vpdb_pkg::CFG_DATA_FORMAT:    fmt_q  <= cfg_data_i[3:0];
        vpdb_pkg::CFG_TWO_COMPONENTS: two_q  <= cfg_data_i[0];
        vpdb_pkg::CFG_NORMALISE:      norm_q <= cfg_data_i[0];
        vpdb_pkg::CFG_BOUNDS_ENABLE:  ben_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Classify the vertex and split a packed word into its three fields.
  always_comb begin
    push_item.ctrl.start = start_req_i;
    push_item.ctrl.fold  = (fmt_q <= vpdb_pkg::FMT_U2101010);
    push_item.ctrl.ben   = ben_q;
    push_item.fmt        = fmt_q;
    push_item.norm       = norm_q;
    push_item.two        = two_q;
    if (fmt_q == vpdb_pkg::FMT_S2101010 || fmt_q == vpdb_pkg::FMT_U2101010) begin
      push_item.raw[0] = {54'd0, comp_x_raw_i[9:0]};
      push_item.raw[1] = {54'd0, comp_x_raw_i[19:10]};
      push_item.raw[2] = {54'd0, comp_x_raw_i[29:20]};
    end else begin
      push_item.raw[0] = comp_x_raw_i;
      push_item.raw[1] = comp_y_raw_i;
      push_item.raw[2] = comp_z_raw_i;
    end
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign push         = in_valid_i & in_ready_o;
  assign pop          = pop_i & head_valid_o;
  assign head_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/vpdb_lane.sv =====
module vpdb_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [3:0]  fmt_i,
  input  logic        norm_i,
  input  logic        zero_i,
  input  logic [63:0] raw_i,
  output logic [31:0] pos_o
);

  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  function automatic logic [3:0] lzc16(input logic [15:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 4'(15 - i);
    end
    return n;
  endfunction

  vpdb_pkg::s1_t s1_d, s1_q;
  vpdb_pkg::s2_t s2_d, s2_q;
  vpdb_pkg::s3_t s3_d, s3_q;
  logic [31:0]   pos_d, pos_q;

  // Unpack: sign, magnitude and the path that finishes the component.
  always_comb begin
    logic [31:0]       v32;
    logic [31:0]       mag;
    logic [31:0]       cmax;
    logic              sgn;
    logic              is_int;
    logic              is_signed;
    logic              narrow;
    vpdb_pkg::rw_e     rw;
    v32       = 32'd0;
    cmax      = 32'd0;
    is_int    = 1'b0;
    is_signed = 1'b0;
    narrow    = 1'b0;
    rw        = vpdb_pkg::RW_8;
    s1_d       = '0;
    s1_d.kind  = vpdb_pkg::KIND_SPEC;
    s1_d.ebase = vpdb_pkg::E_INT;
    s1_d.de    = raw_i[62:52];
    s1_d.dm    = raw_i[51:0];
    unique case (fmt_i)
      vpdb_pkg::FMT_S8: begin
        v32 = {{24{raw_i[7]}}, raw_i[7:0]};
        is_int = 1'b1; is_signed = 1'b1; narrow = 1'b1;
        cmax = 32'd255; rw = vpdb_pkg::RW_8;
      end
      vpdb_pkg::FMT_U8: begin
        v32 = {24'd0, raw_i[7:0]};
        is_int = 1'b1; narrow = 1'b1;
        cmax = 32'd255; rw = vpdb_pkg::RW_8;
      end
      vpdb_pkg::FMT_S16: begin
        v32 = {{16{raw_i[15]}}, raw_i[15:0]};
        is_int = 1'b1; is_signed = 1'b1; narrow = 1'b1;
        cmax = 32'd65535; rw = vpdb_pkg::RW_16;
      end
      vpdb_pkg::FMT_U16: begin
        v32 = {16'd0, raw_i[15:0]};
        is_int = 1'b1; narrow = 1'b1;
        cmax = 32'd65535; rw = vpdb_pkg::RW_16;
      end
      vpdb_pkg::FMT_S32: begin
        v32 = raw_i[31:0];
        is_int = 1'b1; is_signed = 1'b1;
      end
      vpdb_pkg::FMT_U32: begin
        v32 = raw_i[31:0];
        is_int = 1'b1;
      end
      vpdb_pkg::FMT_S2101010: begin
        v32 = {{22{raw_i[9]}}, raw_i[9:0]};
        is_int = 1'b1; is_signed = 1'b1; narrow = 1'b1;
        cmax = 32'd511; rw = vpdb_pkg::RW_9;
      end
      vpdb_pkg::FMT_U2101010: begin
        v32 = {22'd0, raw_i[9:0]};
        is_int = 1'b1; narrow = 1'b1;
        cmax = 32'd1023; rw = vpdb_pkg::RW_10;
      end
      vpdb_pkg::FMT_HALF: begin
        s1_d.sign = raw_i[15];
        if (raw_i[14:10] == 5'h1F) begin
          s1_d.spec = {raw_i[15], 8'hFF, raw_i[9:0], 13'd0};
        end else if (raw_i[14:10] == 5'd0) begin
          // A subnormal half is its mantissa times 2^-24, exact in single.
          if (raw_i[9:0] == 10'd0) begin
            s1_d.spec = {raw_i[15], 31'd0};
          end else begin
            s1_d.kind  = vpdb_pkg::KIND_INT;
            s1_d.mag   = {22'd0, raw_i[9:0]};
            s1_d.ebase = vpdb_pkg::E_HALF_SUB;
          end
        end else begin
          s1_d.spec = {raw_i[15], {3'd0, raw_i[14:10]} + 8'd112, raw_i[9:0], 13'd0};
        end
      end
      vpdb_pkg::FMT_FLOAT: begin
        s1_d.spec = raw_i[31:0];
      end
      vpdb_pkg::FMT_DOUBLE: begin
        s1_d.sign = raw_i[63];
        if (raw_i[62:52] == 11'h7FF) begin
          s1_d.spec = (raw_i[51:0] != 52'd0) ? vpdb_pkg::F32_QNAN
                                             : {raw_i[63], vpdb_pkg::F32_INF[30:0]};
        end else if (raw_i[62:52] == 11'd0) begin
          s1_d.spec = {raw_i[63], 31'd0};
        end else if (raw_i[62:52] >= vpdb_pkg::DBL_EXP_OVF) begin
          s1_d.spec = {raw_i[63], vpdb_pkg::F32_INF[30:0]};
        end else begin
          s1_d.kind = vpdb_pkg::KIND_DBL;
        end
      end
      default: ;
    endcase

    sgn = is_signed & v32[31];
    mag = sgn ? (~v32 + 32'd1) : v32;
    if (is_int) begin
      s1_d.sign = sgn;
      s1_d.mag  = mag;
      s1_d.rw   = rw;
      if (mag == 32'd0) begin
        s1_d.spec = 32'd0;
      end else if (norm_i && narrow) begin
        if (mag == cmax) begin
          s1_d.spec = {sgn, vpdb_pkg::F32_ONE[30:0]};
        end else if (fmt_i == vpdb_pkg::FMT_S2101010 && mag == 32'd512) begin
          s1_d.spec = vpdb_pkg::F32_NEG_512_511;
        end else begin
          s1_d.kind  = vpdb_pkg::KIND_RAT;
          s1_d.ebase = vpdb_pkg::E_RAT;
        end
      end else begin
        s1_d.kind  = vpdb_pkg::KIND_INT;
        s1_d.ebase = norm_i ? vpdb_pkg::E_INT_NORM32 : vpdb_pkg::E_INT;
      end
    end
    if (zero_i) begin
      s1_d.kind = vpdb_pkg::KIND_SPEC;
      s1_d.spec = 32'd0;
    end
  end

  // Leading zero count, exponent and the double's right shift amount.
  always_comb begin
    logic [15:0] r16;
    logic [3:0]  l16;
    r16 = 16'd0;
    unique case (s1_q.rw)
      vpdb_pkg::RW_8:  r16 = {s1_q.mag[7:0], 8'd0};
      vpdb_pkg::RW_16: r16 = s1_q.mag[15:0];
      vpdb_pkg::RW_9:  r16 = {s1_q.mag[8:0], 7'd0};
      vpdb_pkg::RW_10: r16 = {s1_q.mag[9:0], 6'd0};
      default:         r16 = 16'd0;
    endcase
    l16 = lzc16(r16);

    s2_d.kind  = s1_q.kind;
    s2_d.sign  = s1_q.sign;
    s2_d.spec  = s1_q.spec;
    s2_d.mag   = s1_q.mag;
    s2_d.rw    = s1_q.rw;
    s2_d.dm    = s1_q.dm;
    s2_d.lz    = 5'd0;
    s2_d.exp   = 8'd0;
    s2_d.shift = vpdb_pkg::DBL_SH_NORM;
    unique case (s1_q.kind)
      vpdb_pkg::KIND_INT: begin
        s2_d.lz  = lzc32(s1_q.mag);
        s2_d.exp = s1_q.ebase - {3'd0, s2_d.lz};
      end
      vpdb_pkg::KIND_RAT: begin
        s2_d.lz  = {1'b0, l16};
        s2_d.exp = s1_q.ebase - {4'd0, l16};
      end
      vpdb_pkg::KIND_DBL: begin
        if (s1_q.de >= vpdb_pkg::DBL_EXP_NORM) begin
          s2_d.exp = 8'(s1_q.de - vpdb_pkg::DBL_EXP_BIAS);
        end else if (s1_q.de < vpdb_pkg::DBL_EXP_TINY) begin
          s2_d.shift = vpdb_pkg::DBL_SH_MAX;
        end else begin
          s2_d.shift = 6'(vpdb_pkg::DBL_EXP_SUB - s1_q.de);
        end
      end
      default: ;
    endcase
  end

  // Align the significand and collect guard and sticky bits.
  always_comb begin
    logic [31:0]  nm;
    logic [31:0]  rep;
    logic [15:0]  t16;
    logic [31:0]  t32;
    logic [17:0]  t18;
    logic [19:0]  t20;
    logic [116:0] ext;
    nm  = s2_q.mag << s2_q.lz;
    t16 = {s2_q.mag[7:0], s2_q.mag[7:0]} << s2_q.lz[2:0];
    t32 = {s2_q.mag[15:0], s2_q.mag[15:0]} << s2_q.lz[3:0];
    t18 = {s2_q.mag[8:0], s2_q.mag[8:0]} << s2_q.lz[3:0];
    t20 = {s2_q.mag[9:0], s2_q.mag[9:0]} << s2_q.lz[3:0];
    ext = {1'b1, s2_q.dm, 64'd0} >> s2_q.shift;
    // The fraction r/(2^m-1) is r's m-bit block repeated without end,
    // so after the leading one it is the rotated block repeated.
    unique case (s2_q.rw)
      vpdb_pkg::RW_8:  rep = {4{t16[15:8]}};
      vpdb_pkg::RW_16: rep = {2{t32[31:16]}};
      vpdb_pkg::RW_9:  rep = {t18[17:9], t18[17:9], t18[17:9], t18[17:13]};
      vpdb_pkg::RW_10: rep = {t20[19:10], t20[19:10], t20[19:10], t20[19:18]};
      default:         rep = 32'd0;
    endcase

    s3_d.is_spec = (s2_q.kind == vpdb_pkg::KIND_SPEC);
    s3_d.sign    = s2_q.sign;
    s3_d.spec    = s2_q.spec;
    s3_d.exp     = s2_q.exp;
    s3_d.sig     = 24'd0;
    s3_d.guard   = 1'b0;
    s3_d.sticky  = 1'b0;
    unique case (s2_q.kind)
      vpdb_pkg::KIND_INT: begin
        s3_d.sig    = nm[31:8];
        s3_d.guard  = nm[7];
        s3_d.sticky = |nm[6:0];
      end
      vpdb_pkg::KIND_RAT: begin
        s3_d.sig    = rep[31:8];
        s3_d.guard  = rep[7];
        s3_d.sticky = 1'b1;
      end
      vpdb_pkg::KIND_DBL: begin
        s3_d.sig    = ext[87:64];
        s3_d.guard  = ext[63];
        s3_d.sticky = |ext[62:0];
      end
      default: ;
    endcase
  end

  // Round to nearest even; a carry moves naturally into the exponent.
  always_comb begin
    logic        rnd;
    logic [30:0] body;
    rnd   = s3_q.guard & (s3_q.sticky | s3_q.sig[0]);
    body  = {s3_q.exp, s3_q.sig[22:0]} + {30'd0, rnd};
    pos_d = s3_q.is_spec ? s3_q.spec : {s3_q.sign, body};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== rtl/core/vpdb_box.sv =====
module vpdb_box (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  vpdb_pkg::ctrl_t   ctrl_i,
  input  logic [2:0][31:0]  pos_i,
  output logic              out_valid_o,
  output logic [2:0][31:0]  min_o,
  output logic [2:0][31:0]  max_o
);

  // Single precision a < b; false when either is NaN or both are zero.
  function automatic logic f32_lt(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic lt;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (a_nan || b_nan || (a[30:0] == 31'd0 && b[30:0] == 31'd0)) begin
      lt = 1'b0;
    end else if (a[31] != b[31]) begin
      lt = a[31];
    end else if (a[31]) begin
      lt = a[30:0] > b[30:0];
    end else begin
      lt = a[30:0] < b[30:0];
    end
    return lt;
  endfunction

  logic [2:0][31:0] box_min_q, box_max_q;
  logic [2:0][31:0] min_d, max_d;
  logic [2:0][31:0] min_q, max_q;
  logic             out_valid_q;

  always_comb begin
    logic [31:0] base_min;
    logic [31:0] base_max;
    for (int i = 0; i < 3; i++) begin
      base_min = ctrl_i.start ? vpdb_pkg::F32_BOX_MIN : box_min_q[i];
      base_max = ctrl_i.start ? vpdb_pkg::F32_BOX_MAX : box_max_q[i];
      min_d[i] = (ctrl_i.fold && f32_lt(pos_i[i], base_min)) ? pos_i[i] : base_min;
      max_d[i] = (ctrl_i.fold && f32_lt(base_max, pos_i[i])) ? pos_i[i] : base_max;
      if (!ctrl_i.ben) begin
        min_d[i] = 32'd0;
        max_d[i] = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      box_min_q   <= {3{vpdb_pkg::F32_BOX_MIN}};
      box_max_q   <= {3{vpdb_pkg::F32_BOX_MAX}};
    end else if (en_i) begin
      out_valid_q <= valid_i;
      if (valid_i) begin
        box_min_q <= min_d;
        box_max_q <= max_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_o       = min_q;
  assign max_o       = max_q;

endmodule

// ===== rtl/core/vertex_position_decode_bounds_unit.sv =====
// Vertex position decode and bounding box unit. Each input transaction carries
// the raw x, y and z components of one vertex; the block converts them to
// single precision according to the data_format register (signed or unsigned
// 8, 16 and 32 bit integers, half, float, double, and the packed 2_10_10_10
// formats, whose word arrives in comp_x_raw_i), optionally normalizes integer
// formats with correct rounding, folds the vertex into a running box, and
// returns the box after that vertex as one output transaction. start_req_i
// reloads the box to +1e10 / -1e10 before the vertex is folded, and with
// bounds_enable cleared every output is zero. The block sustains one vertex
// per clock cycle while the output is not stalled; each result passes
// through the two-entry input queue, the four-stage conversion pipeline
// (unpack, leading-zero count, align, round) and the output register that
// also updates the box. A stall at the output holds the conversion pipeline,
// while the queue keeps taking transactions until full. Configuration
// writes are always accepted and take effect on the next vertex taken into
// the queue.
module vertex_position_decode_bounds_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic [63:0] comp_x_raw_i,
  input  logic [63:0] comp_y_raw_i,
  input  logic [63:0] comp_z_raw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] min_x_o,
  output logic [31:0] min_y_o,
  output logic [31:0] min_z_o,
  output logic [31:0] max_x_o,
  output logic [31:0] max_y_o,
  output logic [31:0] max_z_o
);

  logic             head_valid;
  vpdb_pkg::item_t  head;
  logic             adv;
  logic [3:0]       pv_q;
  vpdb_pkg::ctrl_t  pc_q [4];
  logic [2:0][31:0] pos;
  logic [2:0][31:0] box_min;
  logic [2:0][31:0] box_max;

  // The whole conversion pipeline moves whenever the output register can
  // take a new result.
  assign adv = ~out_valid_o | out_ready_i;

  vpdb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_req_i  (start_req_i),
    .comp_x_raw_i (comp_x_raw_i),
    .comp_y_raw_i (comp_y_raw_i),
    .comp_z_raw_i (comp_z_raw_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (adv)
  );

  // One conversion lane per component; only z is forced to zero when the
  // position has two components.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    vpdb_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .fmt_i  (head.fmt),
      .norm_i (head.norm),
      .zero_i ((g == 2) && head.two),
      .raw_i  (head.raw[g]),
      .pos_o  (pos[g])
    );
  end

  // Valid bits and per-vertex control travel alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 4'd0;
    end else if (adv) begin
      pv_q <= {pv_q[2:0], head_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pc_q[0] <= head.ctrl;
      for (int k = 1; k < 4; k++) begin
        pc_q[k] <= pc_q[k-1];
      end
    end
  end

  vpdb_box u_box (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (pv_q[3]),
    .ctrl_i      (pc_q[3]),
    .pos_i       (pos),
    .out_valid_o (out_valid_o),
    .min_o       (box_min),
    .max_o       (box_max)
  );

  assign min_x_o = box_min[0];
  assign min_y_o = box_min[1];
  assign min_z_o = box_min[2];
  assign max_x_o = box_max[0];
  assign max_y_o = box_max[1];
  assign max_z_o = box_max[2];

endmodule

// ===== rtl/core/vpdb_checker.sv =====
module vpdb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] min_x_o,
  input logic [31:0] min_y_o,
  input logic [31:0] min_z_o,
  input logic [31:0] max_x_o,
  input logic [31:0] max_y_o,
  input logic [31:0] max_z_o
);

  logic [3:0] outst_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // Vertices accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= 4'd0;
    end else begin
      outst_q <= outst_q + {3'd0, in_acc} - {3'd0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_x_o) &&
    $stable(max_z_o))
    else $error("result transaction changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outst_q != 4'd0)
    else $error("result transaction without an accepted vertex");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= 4'd7)
    else $error("more vertices in flight than the queue and pipeline hold");

  a_no_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((min_x_o[30:23] == 8'hFF && min_x_o[22:0] != 23'd0) ||
                      (min_y_o[30:23] == 8'hFF && min_y_o[22:0] != 23'd0) ||
                      (min_z_o[30:23] == 8'hFF && min_z_o[22:0] != 23'd0) ||
                      (max_x_o[30:23] == 8'hFF && max_x_o[22:0] != 23'd0) ||
                      (max_y_o[30:23] == 8'hFF && max_y_o[22:0] != 23'd0) ||
                      (max_z_o[30:23] == 8'hFF && max_z_o[22:0] != 23'd0)))
    else $error("NaN entered the bounding box");

endmodule

bind vertex_position_decode_bounds_unit vpdb_checker u_vpdb_checker (.*);

// ===== dv/vertex_position_decode_bounds_unit_test.sv =====
`timescale 1ns / 1ps

module vertex_position_decode_bounds_unit_test;

  localparam int NUM_REGS = 4;
  localparam int MAX_IDLE = 9;
  localparam int SETTLE_CYCLES = 12;

  // One result: the box after a vertex, as single precision bit patterns.
  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
  } box_t;

  // A row of the directed table. Rows with a typed box are checked against
  // that box; all others against the predictor.
  typedef struct {
    logic [3:0]  fmt;
    bit          two;
    bit          norm;
    bit          ben;
    bit          start;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    bit          typed;
    box_t        box;
  } vector_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        start_req_i;
  logic [63:0] comp_x_raw_i;
  logic [63:0] comp_y_raw_i;
  logic [63:0] comp_z_raw_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] min_x_o;
  logic [31:0] min_y_o;
  logic [31:0] min_z_o;
  logic [31:0] max_x_o;
  logic [31:0] max_y_o;
  logic [31:0] max_z_o;

  vertex_position_decode_bounds_unit dut (.*);

  // Predictor copy of the configuration registers and the running box.
  logic [3:0]  model_fmt;
  bit          model_two;
  bit          model_norm;
  bit          model_ben;
  logic [31:0] box_lo[3];
  logic [31:0] box_hi[3];

  box_t        pending_boxes[$];
  int          error_count;
  bit          idle_on;
  int          rx_hold;
  vector_t     vectors[$];

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #20ms;
    $display("vertex_position_decode_bounds_unit_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Single precision helpers. Everything is done on bit patterns with
  // integer arithmetic, so the rounding is exact and simulator independent.
  // ---------------------------------------------------------------------

  // Round to nearest even on a sign, exponent and fraction. A carry out of
  // the fraction moves into the exponent, which also produces infinity.
  function automatic logic [31:0] round_pack(logic sign, logic [30:0] em,
                                             logic guard, logic sticky);
    logic [30:0] rounded;
    rounded = em + 31'(guard & (sticky | em[0]));
    return {sign, rounded};
  endfunction

  // sign * mag / divisor * 2^-shift, correctly rounded. The results of all
  // integer formats are normal numbers, so no subnormal handling is needed.
  function automatic logic [31:0] ratio_to_f32(logic sign, logic [32:0] mag,
                                               logic [16:0] divisor, int shift);
    logic [127:0] quot;
    logic [127:0] rem;
    logic [23:0]  sig;
    logic         guard;
    logic         sticky;
    int           lead;
    int           ex;
    if (mag == '0) return {sign, 31'd0};
    quot = {31'd0, mag, 64'd0} / divisor;
    rem  = {31'd0, mag, 64'd0} % divisor;
    lead = 127;
    while (!quot[lead]) lead--;
    sig    = 24'(quot >> (lead - 23));
    guard  = quot[lead - 24];
    sticky = ((quot & ((128'd1 << (lead - 24)) - 1)) != '0) || (rem != '0);
    ex     = lead - 64 - shift + 127;
    return round_pack(sign, {ex[7:0], sig[22:0]}, guard, sticky);
  endfunction

  function automatic logic [31:0] int_to_f32(longint value, bit norm,
                                             logic [16:0] divisor, int shift);
    logic [32:0] mag;
    mag = (value < 0) ? 33'(-value) : 33'(value);
    if (!norm) return ratio_to_f32(value < 0, mag, 17'd1, 0);
    return ratio_to_f32(value < 0, mag, divisor, shift);
  endfunction

  function automatic logic [31:0] half_to_f32(logic [15:0] h);
    logic [4:0] ex;
    ex = h[14:10];
    if (ex == '0) return ratio_to_f32(h[15], 33'(h[9:0]), 17'd1, 24);
    if (ex == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(ex) + 8'd112, h[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] double_to_f32(logic [63:0] d);
    logic        sign;
    logic [10:0] ex;
    logic [51:0] man;
    logic [63:0] sig;
    int          fe;
    int          sh;
    sign = d[63];
    ex   = d[62:52];
    man  = d[51:0];
    if (ex == 11'h7FF) begin
      return (man != '0) ? vpdb_pkg::F32_QNAN : {sign, vpdb_pkg::F32_INF[30:0]};
    end
    if (ex == '0) return {sign, 31'd0};
    fe = int'(ex) - 896;
    if (fe >= 255) return {sign, vpdb_pkg::F32_INF[30:0]};
    if (fe >= 1) return round_pack(sign, {fe[7:0], man[51:29]}, man[28], |man[27:0]);
    // Below the normal range: shift the 53-bit significand into the
    // subnormal fraction field, keeping guard and sticky bits.
    sh = 30 - fe;
    if (sh > 60) return {sign, 31'd0};
    sig = {11'd0, 1'b1, man};
    return round_pack(sign, 31'(sig >> sh), sig[sh - 1],
                      (sig & ((64'd1 << (sh - 1)) - 1)) != '0);
  endfunction

  // Strict less-than on single precision values: false with a NaN, and the
  // two zeros compare equal.
  function automatic bit f32_less(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if ((a[30:23] == 8'hFF && a[22:0] != '0) || (b[30:23] == 8'hFF && b[22:0] != '0))
      return 1'b0;
    if (a[30:0] == '0 && b[30:0] == '0) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka < kb;
  endfunction

  function automatic bit decode_component(logic [63:0] raw, output logic [31:0] val);
    val = '0;
    case (model_fmt)
      vpdb_pkg::FMT_S8:
        val = int_to_f32(longint'($signed(raw[7:0])), model_norm, 17'd255, 0);
      vpdb_pkg::FMT_U8:
        val = int_to_f32(longint'(raw[7:0]), model_norm, 17'd255, 0);
      vpdb_pkg::FMT_S16:
        val = int_to_f32(longint'($signed(raw[15:0])), model_norm, 17'd65535, 0);
      vpdb_pkg::FMT_U16:
        val = int_to_f32(longint'(raw[15:0]), model_norm, 17'd65535, 0);
      vpdb_pkg::FMT_S32:
        val = int_to_f32(longint'($signed(raw[31:0])), model_norm, 17'd1, 32);
      vpdb_pkg::FMT_U32:
        val = int_to_f32(longint'(raw[31:0]), model_norm, 17'd1, 32);
      vpdb_pkg::FMT_HALF:   val = half_to_f32(raw[15:0]);
      vpdb_pkg::FMT_FLOAT:  val = raw[31:0];
      vpdb_pkg::FMT_DOUBLE: val = double_to_f32(raw);
      default:              return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Works out the box after one vertex and advances the predictor state.
  task automatic fold_vertex(bit start, logic [63:0] x, logic [63:0] y,
                             logic [63:0] z, output box_t box);
    logic [31:0] pos[3];
    logic [9:0]  field;
    bit          ok;
    ok = 1'b1;
    if (!model_ben) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] = '0;
        box_hi[i] = '0;
      end
    end else begin
      if (start) begin
        for (int i = 0; i < 3; i++) begin
          box_lo[i] = vpdb_pkg::F32_BOX_MIN;
          box_hi[i] = vpdb_pkg::F32_BOX_MAX;
        end
      end
      if (model_fmt == vpdb_pkg::FMT_S2101010 || model_fmt == vpdb_pkg::FMT_U2101010) begin
        // The packed word sits in the low bits of the x component.
        for (int i = 0; i < 3; i++) begin
          field = x[10 * i +: 10];
          if (model_fmt == vpdb_pkg::FMT_S2101010)
            pos[i] = int_to_f32(longint'($signed(field)), model_norm, 17'd511, 0);
          else
            pos[i] = int_to_f32(longint'(field), model_norm, 17'd1023, 0);
        end
      end else begin
        ok = decode_component(x, pos[0]) && decode_component(y, pos[1]) &&
             decode_component(z, pos[2]);
      end
      if (model_two) pos[2] = '0;
      if (ok) begin
        for (int i = 0; i < 3; i++) begin
          if (f32_less(pos[i], box_lo[i])) box_lo[i] = pos[i];
          if (f32_less(box_hi[i], pos[i])) box_hi[i] = pos[i];
        end
      end
    end
    box = {box_lo[0], box_lo[1], box_lo[2], box_hi[0], box_hi[1], box_hi[2]};
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s is %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Drivers. Every task starts and ends right after a rising edge. A
  // handshake is judged at the falling edge, where inputs and outputs are
  // both settled, and completes at the following rising edge.
  // ---------------------------------------------------------------------

  // Leaves cfg_valid_i high so that back-to-back writes need no toggle.
  task automatic write_reg(logic [3:0] index, logic [31:0] data);
    cfg_index_i <= index;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_ready_o);
    case (index)
      vpdb_pkg::CFG_DATA_FORMAT:    model_fmt  = data[3:0];
      vpdb_pkg::CFG_TWO_COMPONENTS: model_two  = data[0];
      vpdb_pkg::CFG_NORMALISE:      model_norm = data[0];
      vpdb_pkg::CFG_BOUNDS_ENABLE:  model_ben  = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Random upper bits ride along on every write; only the low bits count.
  task automatic configure(logic [3:0] fmt, bit two, bit norm, bit ben);
    write_reg(vpdb_pkg::CFG_DATA_FORMAT, $urandom & 32'hFFFF_FFF0 | 32'(fmt));
    write_reg(vpdb_pkg::CFG_TWO_COMPONENTS, $urandom & 32'hFFFF_FFFE | 32'(two));
    write_reg(vpdb_pkg::CFG_NORMALISE, $urandom & 32'hFFFF_FFFE | 32'(norm));
    if ($urandom_range(0, 3) == 0)
      write_reg(4'(NUM_REGS + $urandom_range(0, 11)), $urandom);
    write_reg(vpdb_pkg::CFG_BOUNDS_ENABLE, $urandom & 32'hFFFF_FFFE | 32'(ben));
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pause: drop valid, wait until every box has come back, then let
  // the pipeline settle so that no vertex is still in flight.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_vertex(bit start, logic [63:0] x, logic [63:0] y, logic [63:0] z,
                             bit typed = 1'b0, box_t typed_box = '0);
    int   gap;
    box_t box;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_req_i  <= start;
    comp_x_raw_i <= x;
    comp_y_raw_i <= y;
    comp_z_raw_i <= z;
    in_valid_i   <= 1'b1;
    do @(negedge clk_i); while (!in_ready_o);
    fold_vertex(start, x, y, z, box);
    pending_boxes = {pending_boxes, (typed ? typed_box : box)};
    @(posedge clk_i);
  endtask

  // Receiver: stalls a random number of cycles per transaction, or for a
  // long stretch when rx_hold is set, then checks the box field by field.
  initial begin
    int   stall;
    box_t want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      if (pending_boxes.size() == 0) begin
        report_mismatch("unexpected box, min_x", min_x_o, 'x);
      end else begin
        want = pending_boxes.pop_front();
        if (min_x_o !== want.min_x) report_mismatch("min_x", min_x_o, want.min_x);
        if (min_y_o !== want.min_y) report_mismatch("min_y", min_y_o, want.min_y);
        if (min_z_o !== want.min_z) report_mismatch("min_z", min_z_o, want.min_z);
        if (max_x_o !== want.max_x) report_mismatch("max_x", max_x_o, want.max_x);
        if (max_y_o !== want.max_y) report_mismatch("max_y", max_y_o, want.max_y);
        if (max_z_o !== want.max_z) report_mismatch("max_z", max_z_o, want.max_z);
      end
      @(posedge clk_i);
    end
  end

  // Component bits for random vertices: mostly random, with a fair share of
  // all-zero and all-one patterns, special float exponents and doubles that
  // land in or near the single precision range.
  function automatic logic [63:0] random_component(logic [3:0] fmt);
    logic [63:0] raw;
    int          pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    case (fmt)
      vpdb_pkg::FMT_HALF:  if (pick < 4) raw[14:10] = (pick == 2) ? 5'h1F : 5'h00;
      vpdb_pkg::FMT_FLOAT: if (pick < 4) raw[30:23] = (pick == 2) ? 8'hFF : 8'h00;
      vpdb_pkg::FMT_DOUBLE: begin
        if (pick == 2) raw[62:52] = 11'h7FF;
        else if (pick < 8) raw[62:52] = 11'($urandom_range(850, 1155));
      end
      default: ;
    endcase
    return raw;
  endfunction

  // Appends one row to the directed table.
  task automatic add_row(logic [3:0] fmt, bit two, bit norm, bit ben,
                         bit start, logic [63:0] x, logic [63:0] y,
                         logic [63:0] z, bit typed = 1'b0,
                         box_t box = '0);
    vector_t v;
    v = '{fmt, two, norm, ben, start, x, y, z, typed, box};
    vectors = {vectors, v};
  endtask

  initial begin
    logic [3:0] fmt;
    bit         two;
    bit         norm;
    bit         ben;
    int         items;

    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    start_req_i  = 1'b0;
    comp_x_raw_i = '0;
    comp_y_raw_i = '0;
    comp_z_raw_i = '0;
    error_count  = 0;
    idle_on      = 1'b1;
    rx_hold      = 0;
    model_fmt    = vpdb_pkg::FMT_FLOAT;
    model_two    = 1'b0;
    model_norm   = 1'b0;
    model_ben    = 1'b1;
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = vpdb_pkg::F32_BOX_MIN;
      box_hi[i] = vpdb_pkg::F32_BOX_MAX;
    end

    // Directed table. The first row runs on the reset configuration.
    add_row(vpdb_pkg::FMT_FLOAT, 0, 0, 1, 1, 64'h3F80_0000, 64'h3F80_0000,
      64'h3F80_0000, 1, {vpdb_pkg::F32_ONE, vpdb_pkg::F32_ONE, vpdb_pkg::F32_ONE,
                         vpdb_pkg::F32_ONE, vpdb_pkg::F32_ONE, vpdb_pkg::F32_ONE});
    // A NaN never enters the box; minus infinity and minus zero do their parts.
    add_row(vpdb_pkg::FMT_FLOAT, 0, 0, 1, 0, 64'hFFFF_FFFF_7FC0_0000,
      64'hFF80_0000, 64'h8000_0000);
    // Byte extremes; higher bits of the components are ignored.
    add_row(vpdb_pkg::FMT_S8, 0, 0, 1, 1, 64'h80, 64'h7F, 64'hFFFF_FFFF_FFFF_FF00,
      1, {32'hC300_0000, 32'h42FE_0000, 32'h0, 32'hC300_0000, 32'h42FE_0000, 32'h0});
    add_row(vpdb_pkg::FMT_U8, 0, 1, 1, 1, 64'hFF, 64'h0, 64'h80);
    add_row(vpdb_pkg::FMT_S16, 0, 1, 1, 1, 64'h8000, 64'h7FFF, 64'h1);
    add_row(vpdb_pkg::FMT_U16, 0, 1, 1, 0, 64'hFFFF, 64'h1, 64'hABCD_0000);
    add_row(vpdb_pkg::FMT_S32, 0, 0, 1, 1, 64'h8000_0000, 64'h7FFF_FFFF,
      64'hFFFF_FFFF);
    add_row(vpdb_pkg::FMT_S32, 0, 1, 1, 0, 64'h8000_0000, 64'h7FFF_FFFF,
      64'h1);
    add_row(vpdb_pkg::FMT_U32, 0, 1, 1, 1, 64'hFFFF_FFFF, 64'h1, 64'h0);
    add_row(vpdb_pkg::FMT_U32, 0, 0, 1, 0, 64'hFFFF_FFFF, 64'h8000_0001, 64'h7);
    // Half: infinity, a NaN, subnormals and the smallest normal.
    add_row(vpdb_pkg::FMT_HALF, 0, 1, 1, 1, 64'h7C00, 64'hFC01, 64'h0001);
    add_row(vpdb_pkg::FMT_HALF, 0, 0, 1, 0, 64'h03FF, 64'h8400, 64'h3C00);
    // Double: infinity, the overflow tie, and a value far below single range.
    add_row(vpdb_pkg::FMT_DOUBLE, 0, 0, 1, 1, 64'h7FF0_0000_0000_0000,
      64'h47EF_FFFF_F000_0000, 64'h1);
    add_row(vpdb_pkg::FMT_DOUBLE, 0, 0, 1, 0, 64'hFFF8_0000_0000_0001,
      64'h3810_0000_0000_0000, 64'h36A0_0000_0000_0000);
    add_row(vpdb_pkg::FMT_DOUBLE, 0, 0, 1, 0, 64'hC7EF_FFFF_EFFF_FFFF,
      64'h8000_0000_0000_0000, 64'h36A0_0000_0000_0001);
    // Signed packed: -512 normalized lands just below -1.
    add_row(vpdb_pkg::FMT_S2101010, 0, 1, 1, 1, 64'hFFFF_FFFF_FFF7_FE00,
      64'h0, 64'h0);
    add_row(vpdb_pkg::FMT_S2101010, 0, 0, 1, 0, 64'h1FF8_01FF, 64'h1, 64'h2);
    add_row(vpdb_pkg::FMT_U2101010, 1, 1, 1, 1, 64'h3FFF_FFFF, 64'h0, 64'h0);
    add_row(vpdb_pkg::FMT_S8, 1, 0, 1, 1, 64'hFF, 64'h80, 64'h7F);
    // Bounds disabled: every lane is zero and the start flag is ignored.
    add_row(vpdb_pkg::FMT_FLOAT, 0, 0, 0, 1, 64'h3F80_0000, 64'h3F80_0000,
      64'h3F80_0000, 1, '0);
    // Enabled again without a start: folds into the zero box.
    add_row(vpdb_pkg::FMT_FLOAT, 0, 0, 1, 0, 64'hBF80_0000, 64'h8000_0000,
      64'h4000_0000);
    // Unknown format: the vertex is dropped but the start still reloads.
    add_row(4'd11, 0, 0, 1, 1, 64'h0, 64'h0, 64'h0, 1,
      {vpdb_pkg::F32_BOX_MIN, vpdb_pkg::F32_BOX_MIN, vpdb_pkg::F32_BOX_MIN,
       vpdb_pkg::F32_BOX_MAX, vpdb_pkg::F32_BOX_MAX, vpdb_pkg::F32_BOX_MAX});
    add_row(4'd15, 0, 1, 1, 0, 64'h3F80_0000, 64'h1, 64'h2);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) begin
      if (vectors[i].fmt != model_fmt || vectors[i].two != model_two ||
          vectors[i].norm != model_norm || vectors[i].ben != model_ben) begin
        wait_drained();
        configure(vectors[i].fmt, vectors[i].two, vectors[i].norm, vectors[i].ben);
      end
      send_vertex(vectors[i].start, vectors[i].x, vectors[i].y, vectors[i].z,
                  vectors[i].typed, vectors[i].box);
    end

    // Random phases. The first eleven walk every defined format; later ones
    // draw the format, now and then an undefined one. Each phase is mostly a
    // stream of models, each opened by a start flag.
    for (int phase = 0; phase < 18; phase++) begin
      wait_drained();
      if (phase < 11) fmt = 4'(phase);
      else if ($urandom_range(0, 5) == 0) fmt = 4'($urandom_range(11, 15));
      else fmt = 4'($urandom_range(0, 10));
      two  = ($urandom_range(0, 3) == 0);
      norm = $urandom_range(0, 1);
      ben  = ($urandom_range(0, 7) != 0);
      configure(fmt, two, norm, ben);
      idle_on = ($urandom_range(0, 3) != 0);
      items   = 90;
      if (phase == 4) begin
        // Long receiver stall with the sender at full rate: the input queue
        // fills and must hold off the sender.
        idle_on = 1'b0;
        rx_hold = 300;
      end
      for (int n = 0; n < items; n++) begin
        if (phase == 7 && n == items / 2) wait_drained();
        send_vertex($urandom_range(0, 19) == 0, random_component(fmt),
                    random_component(fmt), random_component(fmt));
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("vertex_position_decode_bounds_unit_test: clean");
    end else begin
      $display("vertex_position_decode_bounds_unit_test: errors");
    end
    $finish;
  end

endmodule
